/* src/pfab_pkg.sv */
// pfab_pkg: shared types, register codes and helper functions for the
// pixel format alpha blender. No dependencies.
`default_nettype none

package pfab_pkg;

  // pixel formats
  localparam logic [1:0] FMT_RGB565 = 2'd0;
  localparam logic [1:0] FMT_RGB888 = 2'd1;
  localparam logic [1:0] FMT_RGBA   = 2'd2;
  localparam logic [1:0] FMT_PREMUL = 2'd3;

  localparam logic [24:0] KEY_NONE   = '1;
  localparam logic [16:0] RECIP_255  = 17'd65793;
  localparam int          NUM_W      = 17;
  localparam int          LANES      = 3;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_SRC_FMT   = 3'd0,
    REG_DST_FMT   = 3'd1,
    REG_SRC_KEY   = 3'd2,
    REG_DST_KEY   = 3'd3,
    REG_GALPHA    = 3'd4,
    REG_GALPHA_EN = 3'd5
  } pfab_reg_t;

  typedef struct packed {
    logic [1:0]  src_fmt;
    logic [1:0]  dst_fmt;
    logic [24:0] src_key;
    logic [24:0] dst_key;
    logic [7:0]  galpha;
    logic        galpha_en;
  } pfab_cfg_t;

  // one pixel pair as it travels down the pipeline
  typedef struct packed {
    logic        copy;
    logic [15:0] copy_px;
    logic        premul;
    logic [7:0]  s_r, s_g, s_b, s_a;
    logic [7:0]  d_r, d_g, d_b, d_a;
    logic [15:0] m_r, m_g, m_b, m_a;
    logic [15:0] dc_r, dc_g, dc_b;
    logic [15:0] di_r, di_g, di_b, di_a;
    logic [23:0] dx_r, dx_g, dx_b;
    logic [7:0]  o_r, o_g, o_b, o_a;
    logic [7:0]  p_r, p_g, p_b;
    logic [16:0] n_r, n_g, n_b;
  } pfab_item_t;

  // exact x / 255 for x up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return s[15:8];
  endfunction

  // pack channels into the destination format
  function automatic logic [31:0] encode_px(input logic [1:0] fmt, input logic [7:0] r,
                                            input logic [7:0] g, input logic [7:0] b,
                                            input logic [7:0] a, input logic [24:0] key);
    logic [31:0] px;
    case (fmt)
      FMT_RGB565: begin
        if (a == 8'd0 && key != KEY_NONE) px = {16'd0, key[15:0]};
        else px = {16'd0, r[7:3], g[7:2], b[7:3]};
      end
      FMT_RGB888: begin
        if (a == 8'd0 && key != KEY_NONE) px = {8'd0, key[23:0]};
        else px = {8'd0, b, g, r};
      end
      default: px = {a, b, g, r};
    endcase
    return px;
  endfunction

endpackage

`default_nettype wire

/* src/pixel_format_alpha_blender_core.sv */
// pixel_format_alpha_blender_core: top level with configuration registers
// and pipeline control. Uses pfab_pkg, pfab_decode, pfab_front, pfab_div, pfab_encode.
//
// Usage:
//  - input channel: src_pixel and dst_pixel with in_valid / in_stall; a
//    transfer happens when in_valid is high and in_stall is low
//  - output channel: out_pixel with out_valid / out_stall, same rule
//  - configuration: cfg_valid / cfg_ready with cfg_index and cfg_data;
//    cfg_ready is always high; write only while the pipeline is empty
//  - path from input transfer to out_valid: one decode
//    stage, five multiply stages, 17 divider stages (one quotient bit each,
//    set by the 17-bit blend numerator) and the output register
//  - throughput is one pixel per cycle while out_stall stays low
//  - when the output is valid and stalled the whole pipeline holds and
//    in_stall is raised; nothing is lost or repeated
//  - reset clears all valid bits and loads the configuration defaults:
//    RGB565 both sides, no colour keys, global alpha 255 and disabled
`default_nettype none

module pixel_format_alpha_blender_core import pfab_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] src_pixel,
  input  wire logic [31:0] dst_pixel,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_pixel,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [24:0] cfg_data
);

  pfab_cfg_t  cfg;
  logic       adv;
  logic       dec_valid, front_valid, div_valid;
  pfab_item_t dec_item, front_item, div_item;

  // pipeline moves unless the output holds a stalled result
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = out_valid && out_stall;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_fmt   <= FMT_RGB565;
      cfg.dst_fmt   <= FMT_RGB565;
      cfg.src_key   <= KEY_NONE;
      cfg.dst_key   <= KEY_NONE;
      cfg.galpha    <= 8'd255;
      cfg.galpha_en <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (pfab_reg_t'(cfg_index))
        REG_SRC_FMT:   cfg.src_fmt   <= cfg_data[1:0];
        REG_DST_FMT:   cfg.dst_fmt   <= cfg_data[1:0];
        REG_SRC_KEY:   cfg.src_key   <= cfg_data;
        REG_DST_KEY:   cfg.dst_key   <= cfg_data;
        REG_GALPHA:    cfg.galpha    <= cfg_data[7:0];
        REG_GALPHA_EN: cfg.galpha_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pfab_decode u_decode (
    .clk, .rst, .adv, .cfg,
    .in_valid, .src_pixel, .dst_pixel,
    .valid (dec_valid),
    .item  (dec_item)
  );

  pfab_front u_front (
    .clk, .rst, .adv, .cfg,
    .in_valid (dec_valid),
    .in_item  (dec_item),
    .valid    (front_valid),
    .item     (front_item)
  );

  pfab_div u_div (
    .clk, .rst, .adv,
    .in_valid (front_valid),
    .in_item  (front_item),
    .valid    (div_valid),
    .item     (div_item)
  );

  pfab_encode u_encode (
    .clk, .rst, .adv, .cfg,
    .in_valid (div_valid),
    .in_item  (div_item),
    .valid    (out_valid),
    .pixel    (out_pixel)
  );

endmodule

`default_nettype wire

/* src/pfab_decode.sv */
// pfab_decode: input register stage, unpacks both pixels into channels,
// applies colour keys and the direct copy path. Uses pfab_pkg.
`default_nettype none

module pfab_decode import pfab_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        adv,
  input  wire pfab_cfg_t   cfg,
  input  wire logic        in_valid,
  input  wire logic [31:0] src_pixel,
  input  wire logic [31:0] dst_pixel,
  output logic             valid,
  output pfab_item_t       item
);

  // returns {a, b, g, r}
  function automatic logic [31:0] decode_px(input logic [1:0] fmt, input logic [31:0] px,
                                            input logic [24:0] key);
    logic [31:0] c;
    case (fmt)
      FMT_RGB565: begin
        if (key == {9'd0, px[15:0]}) c = '0;
        else c = {8'hFF, px[4:0], 3'b000, px[10:5], 2'b00, px[15:11], 3'b000};
      end
      FMT_RGB888: begin
        if (key == {1'b0, px[23:0]}) c = '0;
        else c = {8'hFF, px[23:0]};
      end
      default: c = px;
    endcase
    return c;
  endfunction

  logic [31:0] sc, dc;
  pfab_item_t  item_next;

  // unpack and set up the copy path
  always_comb begin
    sc = decode_px(cfg.src_fmt, src_pixel, cfg.src_key);
    dc = decode_px(cfg.dst_fmt, dst_pixel, cfg.dst_key);
    item_next = '0;
    item_next.copy = (cfg.src_fmt == FMT_RGB565) && (cfg.dst_fmt == FMT_RGB565) &&
                     !cfg.galpha_en;
    if (cfg.src_key != KEY_NONE && src_pixel[15:0] == cfg.src_key[15:0])
      item_next.copy_px = dst_pixel[15:0];
    else
      item_next.copy_px = src_pixel[15:0];
    item_next.premul = (cfg.src_fmt == FMT_PREMUL);
    {item_next.s_a, item_next.s_b, item_next.s_g, item_next.s_r} = sc;
    {item_next.d_a, item_next.d_b, item_next.d_g, item_next.d_r} = dc;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

/* src/pfab_front.sv */
// pfab_front: five register stages of multiplies and divisions by 255
// that build the blend numerators. Uses pfab_pkg.
`default_nettype none

module pfab_front import pfab_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       adv,
  input  wire pfab_cfg_t  cfg,
  input  wire logic       in_valid,
  input  wire pfab_item_t in_item,
  output logic            valid,
  output pfab_item_t      item
);

  logic       v  [1:5];
  pfab_item_t st [1:5];
  pfab_item_t nx [1:5];

  logic [7:0]  inv;
  logic [40:0] est_r, est_g, est_b;
  logic [23:0] rm_r, rm_g, rm_b;
  logic [15:0] q_r, q_g, q_b;

  always_comb begin
    // global alpha products and destination colour times its alpha
    nx[1] = in_item;
    nx[1].m_r  = 16'(in_item.s_r * cfg.galpha);
    nx[1].m_g  = 16'(in_item.s_g * cfg.galpha);
    nx[1].m_b  = 16'(in_item.s_b * cfg.galpha);
    nx[1].m_a  = 16'(in_item.s_a * cfg.galpha);
    nx[1].dc_r = 16'(in_item.d_r * in_item.d_a);
    nx[1].dc_g = 16'(in_item.d_g * in_item.d_a);
    nx[1].dc_b = 16'(in_item.d_b * in_item.d_a);

    // scale source alpha, and premultiplied source colours, by global alpha when enabled
    nx[2] = st[1];
    if (cfg.galpha_en) begin
      nx[2].s_a = div255(st[1].m_a);
      if (st[1].premul) begin
        nx[2].s_r = div255(st[1].m_r);
        nx[2].s_g = div255(st[1].m_g);
        nx[2].s_b = div255(st[1].m_b);
      end
    end

    // premultiply and destination weight products
    inv = 8'd255 - st[2].s_a;
    nx[3] = st[2];
    nx[3].m_r  = 16'(st[2].s_r * st[2].s_a);
    nx[3].m_g  = 16'(st[2].s_g * st[2].s_a);
    nx[3].m_b  = 16'(st[2].s_b * st[2].s_a);
    nx[3].di_r = 16'(st[2].d_r * inv);
    nx[3].di_g = 16'(st[2].d_g * inv);
    nx[3].di_b = 16'(st[2].d_b * inv);
    nx[3].di_a = 16'(st[2].d_a * inv);
    nx[3].dx_r = 24'(st[2].dc_r * inv);
    nx[3].dx_g = 24'(st[2].dc_g * inv);
    nx[3].dx_b = 24'(st[2].dc_b * inv);

    // opaque results, output alpha, reciprocal estimate of wide quotients
    nx[4] = st[3];
    nx[4].p_r = st[3].premul ? st[3].s_r : div255(st[3].m_r);
    nx[4].p_g = st[3].premul ? st[3].s_g : div255(st[3].m_g);
    nx[4].p_b = st[3].premul ? st[3].s_b : div255(st[3].m_b);
    nx[4].o_r = nx[4].p_r + div255(st[3].di_r);
    nx[4].o_g = nx[4].p_g + div255(st[3].di_g);
    nx[4].o_b = nx[4].p_b + div255(st[3].di_b);
    nx[4].o_a = st[3].s_a + div255(st[3].di_a);
    est_r = st[3].dx_r * RECIP_255;
    est_g = st[3].dx_g * RECIP_255;
    est_b = st[3].dx_b * RECIP_255;
    nx[4].m_r = est_r[39:24];
    nx[4].m_g = est_g[39:24];
    nx[4].m_b = est_b[39:24];

    // correct the estimate and form numerators
    rm_r = st[4].dx_r - ({st[4].m_r, 8'd0} - {8'd0, st[4].m_r});
    rm_g = st[4].dx_g - ({st[4].m_g, 8'd0} - {8'd0, st[4].m_g});
    rm_b = st[4].dx_b - ({st[4].m_b, 8'd0} - {8'd0, st[4].m_b});
    q_r = st[4].m_r + {15'd0, (rm_r >= 24'd255)};
    q_g = st[4].m_g + {15'd0, (rm_g >= 24'd255)};
    q_b = st[4].m_b + {15'd0, (rm_b >= 24'd255)};
    nx[5] = st[4];
    nx[5].n_r = {1'b0, st[4].p_r, 8'd0} - {9'd0, st[4].p_r} + {1'b0, q_r};
    nx[5].n_g = {1'b0, st[4].p_g, 8'd0} - {9'd0, st[4].p_g} + {1'b0, q_g};
    nx[5].n_b = {1'b0, st[4].p_b, 8'd0} - {9'd0, st[4].p_b} + {1'b0, q_b};
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= 5; k++) v[k] <= 1'b0;
    end else if (adv) begin
      v[1] <= in_valid;
      for (int k = 2; k <= 5; k++) v[k] <= v[k-1];
    end
  end

  // stage data
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 1; k <= 5; k++) st[k] <= nx[k];
    end
  end

  assign valid = v[5];
  assign item  = st[5];

endmodule

`default_nettype wire

/* src/pfab_div.sv */
// pfab_div: pipelined restoring divider, one quotient bit per stage for
// three colour lanes, divisor is the output alpha. Uses pfab_pkg.
`default_nettype none

module pfab_div import pfab_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       adv,
  input  wire logic       in_valid,
  input  wire pfab_item_t in_item,
  output logic            valid,
  output pfab_item_t      item
);

  logic             v   [0:NUM_W];
  pfab_item_t       it  [0:NUM_W];
  logic [7:0]       rem [0:NUM_W][LANES];
  logic [NUM_W-1:0] nq  [0:NUM_W][LANES];

  // stage zero is the incoming item
  assign v[0]      = in_valid;
  assign it[0]     = in_item;
  assign rem[0][0] = '0;
  assign rem[0][1] = '0;
  assign rem[0][2] = '0;
  assign nq[0][0]  = in_item.n_r;
  assign nq[0][1]  = in_item.n_g;
  assign nq[0][2]  = in_item.n_b;

  for (genvar k = 1; k <= NUM_W; k++) begin : g_step
    logic [8:0] rs [LANES];
    logic       ge [LANES];

    // one restoring step per lane
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        rs[l] = {rem[k-1][l], nq[k-1][l][NUM_W-1]};
        ge[l] = (rs[l] >= {1'b0, it[k-1].o_a});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (adv) begin
        v[k] <= v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        it[k] <= it[k-1];
        for (int l = 0; l < LANES; l++) begin
          rem[k][l] <= ge[l] ? 8'(rs[l] - {1'b0, it[k-1].o_a}) : rs[l][7:0];
          nq[k][l]  <= {nq[k-1][l][NUM_W-2:0], ge[l]};
        end
      end
    end
  end

  // quotients replace the premultiplied colours on the way out
  always_comb begin
    item     = it[NUM_W];
    item.p_r = nq[NUM_W][0][7:0];
    item.p_g = nq[NUM_W][1][7:0];
    item.p_b = nq[NUM_W][2][7:0];
  end

  assign valid = v[NUM_W];

endmodule

`default_nettype wire

/* src/pfab_encode.sv */
// pfab_encode: picks the blend case, re-encodes into the destination
// format and holds the output register. Uses pfab_pkg.
`default_nettype none

module pfab_encode import pfab_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       adv,
  input  wire pfab_cfg_t  cfg,
  input  wire logic       in_valid,
  input  wire pfab_item_t in_item,
  output logic            valid,
  output logic [31:0]     pixel
);

  logic [7:0]  r, g, b, a;
  logic [31:0] pixel_next;

  // choose the result channels
  always_comb begin
    if (in_item.s_a == 8'd0) begin
      {r, g, b, a} = {in_item.d_r, in_item.d_g, in_item.d_b, in_item.d_a};
    end else if (in_item.s_a == 8'd255) begin
      {r, g, b, a} = {in_item.s_r, in_item.s_g, in_item.s_b, in_item.s_a};
    end else if (in_item.d_a == 8'd255) begin
      {r, g, b, a} = {in_item.o_r, in_item.o_g, in_item.o_b, 8'd255};
    end else begin
      {r, g, b, a} = {in_item.p_r, in_item.p_g, in_item.p_b, in_item.o_a};
    end
    if (in_item.copy) pixel_next = {16'd0, in_item.copy_px};
    else pixel_next = encode_px(cfg.dst_fmt, r, g, b, a, cfg.dst_key);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pixel <= pixel_next;
    end
  end

endmodule

`default_nettype wire

/* src/pfab_checker.sv */
// pfab_checker: port level assertions for the blender top level, bound
// to pixel_format_alpha_blender_core. No package dependencies.
`default_nettype none

module pfab_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_pixel,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_pixel))
    else $error("stalled output changed");

  // input backpressure only comes from a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // configuration writes never wait
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write held off");

endmodule

bind pixel_format_alpha_blender_core pfab_checker u_pfab_checker (.*);

`default_nettype wire
